>>> design/pfe_pkg.sv
`default_nettype none
package pfe_pkg;

    localparam int WIDTH_BITS = 6;

    // command codes from front to back
    localparam logic [2:0] OP_CHAR = 3'd0;
    localparam logic [2:0] OP_NUM  = 3'd1;
    localparam logic [2:0] OP_NULL = 3'd2;
    localparam logic [2:0] OP_FIN  = 3'd3;

    // number base codes
    localparam logic [1:0] BASE_DEC = 2'd0;
    localparam logic [1:0] BASE_HEX = 2'd1;
    localparam logic [1:0] BASE_OCT = 2'd2;

    // prefix codes
    localparam logic [1:0] PRE_NONE  = 2'd0;
    localparam logic [1:0] PRE_MINUS = 2'd1;
    localparam logic [1:0] PRE_HEX   = 2'd2;

    typedef struct packed {
        logic [2:0]            op;
        logic [7:0]            ch;
        logic [31:0]           value;
        logic [1:0]            base;
        logic [1:0]            pre;
        logic [WIDTH_BITS-1:0] width;
    } t_cmd;

    // characters of the null string text
    function automatic logic [7:0] null_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h28;
            3'd1:    c = 8'h6E;
            3'd2:    c = 8'h75;
            3'd3:    c = 8'h6C;
            3'd4:    c = 8'h6C;
            default: c = 8'h29;
        endcase
        return c;
    endfunction

    // digit value to ascii, upper-case letters
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d <= 4'd9) begin
            c = 8'h30 + {4'd0, d};
        end else begin
            c = 8'h41 + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

>>> design/pfe_front.sv
`default_nettype none
module pfe_front #(
    parameter int MAX_WIDTH = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire logic [2:0]     i_mode,
    input  wire logic [31:0]    i_value,
    output pfe_pkg::t_cmd       o_cmd,
    output logic                o_push
);

    localparam logic [2:0] PH_NORMAL  = 3'd0;
    localparam logic [2:0] PH_PERCENT = 3'd1;
    localparam logic [2:0] PH_WIDTH   = 3'd2;
    localparam logic [2:0] PH_ARG     = 3'd3;
    localparam logic [2:0] PH_STRING  = 3'd4;

    localparam logic [2:0] K_SIGNED = 3'd1;
    localparam logic [2:0] K_UDEC   = 3'd2;
    localparam logic [2:0] K_HEX    = 3'd3;
    localparam logic [2:0] K_OCT    = 3'd4;
    localparam logic [2:0] K_CHAR   = 3'd5;
    localparam logic [2:0] K_PTR    = 3'd6;

    localparam logic [2:0] M_FMT  = 3'd0;
    localparam logic [2:0] M_STR  = 3'd2;
    localparam logic [2:0] M_NULL = 3'd3;
    localparam logic [2:0] M_END  = 3'd4;

    logic [2:0]                     r_phase, n_phase;
    logic [2:0]                     r_kind, n_kind;
    logic [pfe_pkg::WIDTH_BITS-1:0] r_width, n_width;
    logic [7:0]                     b;
    logic [9:0]                     wsum;
    logic                           is_fmt;

    assign b      = i_value[7:0];
    assign is_fmt = (i_mode == M_FMT);
    assign wsum   = 10'(r_width) * 10'd10 + 10'(b - 8'h30);

    // classify one item into at most one back-end command
    always_comb begin
        n_phase = r_phase;
        n_kind  = r_kind;
        n_width = r_width;
        o_push  = 1'b0;
        o_cmd   = '{op: pfe_pkg::OP_CHAR, ch: b, value: i_value,
                    base: pfe_pkg::BASE_DEC, pre: pfe_pkg::PRE_NONE, width: r_width};
        if (i_mode == M_END) begin
            o_push   = 1'b1;
            o_cmd.op = pfe_pkg::OP_FIN;
            n_phase  = PH_NORMAL;
            n_kind   = '0;
            n_width  = '0;
        end else if (i_mode < M_END) begin
            unique case (r_phase)
                PH_NORMAL, PH_STRING: begin
                    if (r_phase == PH_STRING && i_mode == M_STR) begin
                        if (b == 8'h00) begin
                            n_phase = PH_NORMAL;
                        end else begin
                            o_push = 1'b1;
                        end
                    end else if (r_phase == PH_STRING && i_mode == M_NULL) begin
                        o_push   = 1'b1;
                        o_cmd.op = pfe_pkg::OP_NULL;
                        n_phase  = PH_NORMAL;
                    end else if (is_fmt) begin
                        n_phase = PH_NORMAL;
                        if (b == 8'h00) begin
                            o_push   = 1'b1;
                            o_cmd.op = pfe_pkg::OP_FIN;
                            n_kind   = '0;
                            n_width  = '0;
                        end else if (b == 8'h25) begin
                            n_phase = PH_PERCENT;
                            n_width = '0;
                        end else begin
                            o_push = 1'b1;
                        end
                    end
                end
                PH_PERCENT, PH_WIDTH: begin
                    if (is_fmt) begin
                        if (r_phase == PH_PERCENT && b == 8'h30) begin
                            n_phase = PH_WIDTH;
                        end else if (r_phase == PH_WIDTH && b >= 8'h30 && b <= 8'h39) begin
                            if (wsum > 10'(MAX_WIDTH)) begin
                                n_width = pfe_pkg::WIDTH_BITS'(MAX_WIDTH);
                            end else begin
                                n_width = wsum[pfe_pkg::WIDTH_BITS-1:0];
                            end
                        end else begin
                            // dispatch on the conversion letter
                            n_phase = PH_ARG;
                            priority case (b)
                                8'h64, 8'h69: n_kind = K_SIGNED;
                                8'h75:        n_kind = K_UDEC;
                                8'h78:        n_kind = K_HEX;
                                8'h6F:        n_kind = K_OCT;
                                8'h63:        n_kind = K_CHAR;
                                8'h70:        n_kind = K_PTR;
                                8'h73:        n_phase = PH_STRING;
                                8'h00: begin
                                    o_push   = 1'b1;
                                    o_cmd.op = pfe_pkg::OP_FIN;
                                    n_phase  = PH_NORMAL;
                                    n_kind   = '0;
                                    n_width  = '0;
                                end
                                default: begin
                                    o_push  = 1'b1;
                                    n_phase = PH_NORMAL;
                                end
                            endcase
                        end
                    end
                end
                PH_ARG: begin
                    o_push   = 1'b1;
                    o_cmd.op = pfe_pkg::OP_NUM;
                    n_phase  = PH_NORMAL;
                    priority case (r_kind)
                        K_SIGNED: begin
                            if (i_value[31]) begin
                                o_cmd.pre   = pfe_pkg::PRE_MINUS;
                                o_cmd.value = 32'd0 - i_value;
                            end
                        end
                        K_UDEC: o_cmd.base = pfe_pkg::BASE_DEC;
                        K_HEX:  o_cmd.base = pfe_pkg::BASE_HEX;
                        K_OCT:  o_cmd.base = pfe_pkg::BASE_OCT;
                        K_CHAR: o_cmd.op   = pfe_pkg::OP_CHAR;
                        default: begin
                            o_cmd.base  = pfe_pkg::BASE_HEX;
                            o_cmd.pre   = pfe_pkg::PRE_HEX;
                            o_cmd.width = pfe_pkg::WIDTH_BITS'(8);
                        end
                    endcase
                end
                default: n_phase = PH_NORMAL;
            endcase
        end
    end

    // message state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NORMAL;
            r_kind  <= '0;
            r_width <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_width <= n_width;
        end
    end

endmodule
`default_nettype wire

>>> design/pfe_queue.sv
`default_nettype none
module pfe_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  pfe_pkg::t_cmd       i_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_empty,
    output pfe_pkg::t_cmd       o_cmd
);

    pfe_pkg::t_cmd r_slot [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_slot[r_rp];

    // two-entry command queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

>>> design/pfe_back.sv
`default_nettype none
module pfe_back #(
    parameter int DIGIT_SLOTS = 12
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [30:0]    i_buffer_size,
    input  wire logic           i_empty,
    input  pfe_pkg::t_cmd       i_cmd,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output logic [7:0]          o_out_char,
    output logic                o_end_of_message
);

    localparam int LW = $clog2(DIGIT_SLOTS + 1);
    localparam int IW = $clog2(DIGIT_SLOTS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHAR = 3'd1;
    localparam logic [2:0] S_PRE  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_PAD  = 3'd4;
    localparam logic [2:0] S_DIG  = 3'd5;
    localparam logic [2:0] S_NULL = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0]                     r_state, n_state;
    logic [31:0]                    r_v;
    logic [1:0]                     r_base, r_pre;
    logic [pfe_pkg::WIDTH_BITS-1:0] r_width;
    logic [LW-1:0]                  r_len;
    logic                           r_pcnt;
    logic [2:0]                     r_nidx;
    logic [7:0]                     r_ch;
    logic [30:0]                    r_count;
    logic [3:0]                     r_digits [DIGIT_SLOTS];
    logic                           r_out_valid;
    logic [7:0]                     r_out_char;
    logic                           r_eom;

    logic        go, emit, emit_eom, load, advance;
    logic [7:0]  emit_char;
    logic [30:0] lim;
    logic [63:0] prod;
    logic [31:0] q;
    logic [3:0]  dig;
    logic [LW-1:0] len_inc;

    assign o_out_valid      = r_out_valid;
    assign o_out_char       = r_out_char;
    assign o_end_of_message = r_eom;

    assign go      = !r_out_valid || !i_out_stall;
    assign lim     = (i_buffer_size == 31'd0) ? 31'd0 : i_buffer_size - 31'd1;
    assign o_pop   = (r_state == S_IDLE) && !i_empty;
    assign prod    = 64'(r_v) * 64'hCCCC_CCCD;
    assign len_inc = r_len + LW'(1);

    // one digit per cycle: divide by ten via reciprocal, else shift
    always_comb begin
        unique case (r_base)
            pfe_pkg::BASE_HEX: begin
                q   = r_v >> 4;
                dig = r_v[3:0];
            end
            pfe_pkg::BASE_OCT: begin
                q   = r_v >> 3;
                dig = {1'b0, r_v[2:0]};
            end
            default: begin
                q   = {3'd0, prod[63:35]};
                dig = 4'(r_v - ((q << 3) + (q << 1)));
            end
        endcase
    end

    // character to emit in the current state
    always_comb begin
        emit      = 1'b0;
        emit_eom  = 1'b0;
        emit_char = 8'h30;
        n_state   = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    unique case (i_cmd.op)
                        pfe_pkg::OP_CHAR: n_state = S_CHAR;
                        pfe_pkg::OP_NUM:  n_state =
                            (i_cmd.pre == pfe_pkg::PRE_NONE) ? S_DIV : S_PRE;
                        pfe_pkg::OP_NULL: n_state = S_NULL;
                        default:          n_state = S_FIN;
                    endcase
                end
            end
            S_CHAR: begin
                emit      = 1'b1;
                emit_char = r_ch;
                n_state   = S_IDLE;
            end
            S_PRE: begin
                emit = 1'b1;
                if (r_pre == pfe_pkg::PRE_MINUS) begin
                    emit_char = 8'h2D;
                    n_state   = S_DIV;
                end else if (!r_pcnt) begin
                    emit_char = 8'h30;
                end else begin
                    emit_char = 8'h78;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (q == 32'd0 || len_inc >= LW'(DIGIT_SLOTS)) begin
                    n_state = S_PAD;
                end
            end
            S_PAD: begin
                if (r_width > pfe_pkg::WIDTH_BITS'(r_len)) begin
                    emit = 1'b1;
                end else begin
                    n_state = S_DIG;
                end
            end
            S_DIG: begin
                emit      = 1'b1;
                emit_char = pfe_pkg::digit_char(r_digits[IW'(r_len - LW'(1))]);
                if (r_len == LW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            S_NULL: begin
                emit      = 1'b1;
                emit_char = pfe_pkg::null_char(r_nidx);
                if (r_nidx == 3'd5) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                emit      = 1'b1;
                emit_eom  = 1'b1;
                emit_char = 8'h00;
                n_state   = S_IDLE;
            end
        endcase
    end

    // an emitting state waits for a free output slot; over-limit chars are dropped
    assign advance = !emit || go;
    assign load    = emit && go && (emit_eom || (r_count < lim));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_state <= n_state;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (load) begin
                r_count <= emit_eom ? 31'd0 : r_count + 31'd1;
            end
        end
    end

    // output register and sequencer payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_char <= emit_char;
            r_eom      <= emit_eom;
        end
        if (o_pop) begin
            r_v     <= i_cmd.value;
            r_base  <= i_cmd.base;
            r_pre   <= i_cmd.pre;
            r_width <= i_cmd.width;
            r_ch    <= i_cmd.ch;
            r_len   <= '0;
            r_pcnt  <= 1'b0;
            r_nidx  <= '0;
        end else if (advance) begin
            unique case (r_state)
                S_PRE:  r_pcnt <= 1'b1;
                S_DIV: begin
                    r_digits[IW'(r_len)] <= dig;
                    r_v   <= q;
                    r_len <= len_inc;
                end
                S_PAD: begin
                    if (r_width > pfe_pkg::WIDTH_BITS'(r_len)) begin
                        r_width <= r_width - pfe_pkg::WIDTH_BITS'(1);
                    end
                end
                S_DIG:  r_len  <= r_len - LW'(1);
                S_NULL: r_nidx <= r_nidx + 3'd1;
                default: r_pcnt <= r_pcnt;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> design/printf_format_engine_core.sv
`default_nettype none
// Streaming printf formatter. One item per transfer on the input (format byte,
// argument word, string byte, null string, end of format); characters leave one
// per transfer on the output, the terminating NUL flagged with o_end_of_message.
// A front decoder tracks the format state and queues at most one command per
// item in a two-entry queue; a back sequencer expands it into characters. A
// literal or string byte is dispatched and then emitted, a null string is
// dispatched and emits its six characters, and an end of format is dispatched
// and emits the NUL. A number is dispatched, emits a sign or a 0x prefix if it
// has one, extracts its digits one at a time (up to 11 for octal, 10 for
// decimal), turns around, and emits its pad characters and then its digits.
// Output stalls hold the sequencer, and the input stalls while the queue is
// full. Characters past buffer_size-1 are silently dropped.
module printf_format_engine_core #(
    parameter int MAX_WIDTH   = 32,
    parameter int DIGIT_SLOTS = 12
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [30:0]    i_cfg_data,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire logic [2:0]     i_mode,
    input  wire logic [31:0]    i_value,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output logic [7:0]          o_out_char,
    output logic                o_end_of_message
);

    logic [30:0]   r_buffer_size;
    logic          accept, push, full, empty, pop;
    pfe_pkg::t_cmd cmd_in, cmd_out;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    // buffer size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_size <= 31'd1024;
        end else if (i_cfg_we) begin
            r_buffer_size <= i_cfg_data;
        end
    end

    pfe_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_mode  (i_mode),
        .i_value (i_value),
        .o_cmd   (cmd_in),
        .o_push  (push)
    );

    pfe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (cmd_out)
    );

    pfe_back #(.DIGIT_SLOTS(DIGIT_SLOTS)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_buffer_size   (r_buffer_size),
        .i_empty         (empty),
        .i_cmd           (cmd_out),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_char      (o_out_char),
        .o_end_of_message(o_end_of_message)
    );

endmodule
`default_nettype wire

>>> design/pfe_checker.sv
`default_nettype none
module pfe_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [7:0]  o_out_char,
    input wire logic        o_end_of_message
);

    // a stalled transfer holds its character
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_char)
            && $stable(o_end_of_message))
        else $error("output changed while stalled");

    // end of message always carries the NUL
    a_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_of_message |-> o_out_char == 8'h00)
        else $error("end of message without NUL");

    // reset empties the output
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // reset empties the queue
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

endmodule

bind printf_format_engine_core pfe_checker u_pfe_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_out_char      (o_out_char),
    .o_end_of_message(o_end_of_message)
);
`default_nettype wire

>>> test/tb_printf_format_engine_core.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_printf_format_engine_core;

    localparam int MAX_WIDTH   = 32;
    localparam int DIGIT_SLOTS = 12;
    localparam int CYCLE_LIMIT = 900000;

    // input modes
    localparam logic [2:0] MODE_FMT  = 3'd0;
    localparam logic [2:0] MODE_ARG  = 3'd1;
    localparam logic [2:0] MODE_STR  = 3'd2;
    localparam logic [2:0] MODE_NULL = 3'd3;
    localparam logic [2:0] MODE_END  = 3'd4;

    typedef enum logic [2:0] {
        PH_TEXT, PH_PCT, PH_WID, PH_ARGW, PH_STRG
    } t_phase;

    typedef enum logic [2:0] {
        CV_NONE, CV_SDEC, CV_UDEC, CV_HEX, CV_OCT, CV_CHR, CV_PTR
    } t_conv;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] value;
    } t_item;

    typedef struct packed {
        logic [7:0] ch;
        logic       eom;
    } t_char;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [30:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_mode;
    logic [31:0] i_value;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_out_char;
    logic        o_end_of_message;

    printf_format_engine_core #(
        .MAX_WIDTH(MAX_WIDTH),
        .DIGIT_SLOTS(DIGIT_SLOTS)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_mode(i_mode),
        .i_value(i_value),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_char(o_out_char),
        .o_end_of_message(o_end_of_message)
    );

    // formatter shadow state
    logic [30:0] buf_size;
    t_phase      ph;
    t_conv       conv;
    logic [5:0]  width_acc;
    logic [30:0] char_count;

    t_item pending_items[$];
    t_char expected_chars[$];
    int    errors;
    int    cycles;
    int    send_idle_pct;
    int    recv_idle_pct;

    // emit one character subject to the buffer limit
    function automatic void emit(input logic [7:0] c);
        logic [30:0] lim;
        lim = (buf_size == 0) ? 31'd0 : buf_size - 31'd1;
        if (char_count < lim) begin
            expected_chars.push_back('{ch: c, eom: 1'b0});
            char_count++;
        end
    endfunction

    function automatic void end_message();
        expected_chars.push_back('{ch: 8'h00, eom: 1'b1});
        ph = PH_TEXT;
        conv = CV_NONE;
        width_acc = 0;
        char_count = 0;
    endfunction

    function automatic void emit_number(input logic [31:0] v, input int radix, input int wid);
        logic [3:0] digs[DIGIT_SLOTS];
        int len;
        len = 0;
        do begin
            digs[len] = 4'(v % radix);
            len++;
            v = v / radix;
        end while (v != 0 && len < DIGIT_SLOTS);
        while (wid > len) begin
            emit("0");
            wid--;
        end
        while (len > 0) begin
            len--;
            emit(digs[len] <= 9 ? 8'h30 + digs[len] : 8'h41 + digs[len] - 8'd10);
        end
    endfunction

    function automatic void plain_byte(input logic [7:0] b);
        if (b == 0) begin
            end_message();
        end else if (b == "%") begin
            ph = PH_PCT;
            width_acc = 0;
        end else begin
            emit(b);
        end
    endfunction

    function automatic void pick_conversion(input logic [7:0] b);
        ph = PH_ARGW;
        case (b)
            "d", "i": conv = CV_SDEC;
            "u": conv = CV_UDEC;
            "x": conv = CV_HEX;
            "o": conv = CV_OCT;
            "c": conv = CV_CHR;
            "p": conv = CV_PTR;
            "s": ph = PH_STRG;
            8'h00: end_message();
            default: begin
                ph = PH_TEXT;
                emit(b);
            end
        endcase
    endfunction

    // predict the characters caused by one accepted item
    function automatic void format_item(input t_item it);
        logic [7:0]  b;
        logic [31:0] v;
        int          w;
        b = it.value[7:0];
        v = it.value;
        if (it.mode == MODE_END) begin
            end_message();
            return;
        end
        if (it.mode > MODE_END) return;
        case (ph)
            PH_TEXT: if (it.mode == MODE_FMT) plain_byte(b);
            PH_PCT: if (it.mode == MODE_FMT) begin
                if (b == "0") ph = PH_WID;
                else pick_conversion(b);
            end
            PH_WID: if (it.mode == MODE_FMT) begin
                if (b >= "0" && b <= "9") begin
                    w = int'(width_acc) * 10 + int'(b - "0");
                    width_acc = (w > MAX_WIDTH) ? 6'(MAX_WIDTH) : 6'(w);
                end else begin
                    pick_conversion(b);
                end
            end
            PH_ARGW: begin
                case (conv)
                    CV_SDEC: begin
                        if (v[31]) begin
                            emit("-");
                            v = -v;
                        end
                        emit_number(v, 10, width_acc);
                    end
                    CV_UDEC: emit_number(v, 10, width_acc);
                    CV_HEX: emit_number(v, 16, width_acc);
                    CV_OCT: emit_number(v, 8, width_acc);
                    CV_CHR: emit(v[7:0]);
                    default: begin
                        emit("0");
                        emit("x");
                        emit_number(v, 16, 8);
                    end
                endcase
                ph = PH_TEXT;
            end
            PH_STRG: begin
                if (it.mode == MODE_STR) begin
                    if (b == 0) ph = PH_TEXT;
                    else emit(b);
                end else if (it.mode == MODE_NULL) begin
                    emit("(");
                    emit("n");
                    emit("u");
                    emit("l");
                    emit("l");
                    emit(")");
                    ph = PH_TEXT;
                end else if (it.mode == MODE_FMT) begin
                    ph = PH_TEXT;
                    plain_byte(b);
                end
            end
            default: ph = PH_TEXT;
        endcase
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && o_in_stall)) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_mode <= pending_items[0].mode;
                i_value <= pending_items[0].value;
                void'(pending_items.pop_front());
            end else begin
                i_in_valid <= 1'b0;
                i_mode <= 3'($urandom);
                i_value <= $urandom;
            end
        end
    end

    // output stall
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // predict on input transfer, check on output transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            cycles <= cycles + 1;
            if (i_in_valid && !o_in_stall) format_item('{mode: i_mode, value: i_value});
            if (o_out_valid && !i_out_stall) begin
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected char expected none actual %h eom %b",
                             $time, o_out_char, o_end_of_message);
                    errors++;
                end else begin
                    if (o_out_char !== expected_chars[0].ch) begin
                        $display("%0t: char mismatch expected %h actual %h",
                                 $time, expected_chars[0].ch, o_out_char);
                        errors++;
                    end
                    if (o_end_of_message !== expected_chars[0].eom) begin
                        $display("%0t: end_of_message mismatch expected %b actual %b",
                                 $time, expected_chars[0].eom, o_end_of_message);
                        errors++;
                    end
                    void'(expected_chars.pop_front());
                end
            end
            if (cycles > CYCLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic add(input logic [2:0] m, input logic [31:0] v);
        pending_items.push_back('{mode: m, value: v});
    endtask

    task automatic add_text(input string s);
        for (int k = 0; k < s.len(); k++) add(MODE_FMT, {24'($urandom), s[k]});
    endtask

    // wait until every queued item has gone and all characters arrived
    task automatic drain();
        while (pending_items.size() > 0 || i_in_valid || expected_chars.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [30:0] sz);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= sz;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        buf_size = sz;
    endtask

    function automatic logic [31:0] rand_arg();
        case ($urandom_range(4))
            0: return 32'hFFFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(20);
            default: return $urandom;
        endcase
    endfunction

    // one random message: mostly well-formed pieces, some noise
    task automatic add_random_message();
        int pieces;
        string convs;
        convs = "diuxocpsq%";
        pieces = $urandom_range(1, 6);
        for (int p = 0; p < pieces; p++) begin
            case ($urandom_range(9))
                0, 1: add(MODE_FMT, {24'($urandom), 8'($urandom_range(1, 255))});
                2: add(3'($urandom_range(1, 7)), $urandom);
                default: begin
                    logic [7:0] cv;
                    cv = convs[$urandom_range(convs.len() - 1)];
                    add(MODE_FMT, "%");
                    if ($urandom_range(2) == 0) begin
                        add(MODE_FMT, "0");
                        repeat ($urandom_range(1, 3))
                            add(MODE_FMT, 8'h30 + 8'($urandom_range(9)));
                    end
                    if ($urandom_range(15) == 0) cv = 8'h00;
                    add(MODE_FMT, cv);
                    if (cv == "s") begin
                        if ($urandom_range(3) == 0) begin
                            add(MODE_NULL, $urandom);
                        end else begin
                            repeat ($urandom_range(0, 4))
                                add(MODE_STR, {24'($urandom), 8'($urandom_range(1, 255))});
                            if ($urandom_range(3) == 0) add(MODE_ARG, $urandom);
                            if ($urandom_range(1)) add(MODE_STR, {24'($urandom), 8'h00});
                        end
                    end else if (cv != "q" && cv != "%" && cv != 0) begin
                        add(3'($urandom_range(3)), rand_arg());
                    end
                end
            endcase
        end
        if ($urandom_range(7) == 0) add(MODE_FMT, 32'h0000_0000);
        else add(MODE_END, $urandom);
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        send_idle_pct = 28;
        recv_idle_pct = 73;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_mode = '0;
        i_value = '0;
        i_out_stall = 1'b0;
        buf_size = 31'd1024;
        ph = PH_TEXT;
        conv = CV_NONE;
        width_acc = 0;
        char_count = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: every conversion, widths, strings, special cases
        add_text("A%%%05d%i%u%x%o%c%p");
        add(MODE_ARG, 32'h8000_0000);
        add(MODE_FMT, 32'hFFFF_FF00 | "-");
        add(MODE_ARG, 32'hFFFF_FFFF);
        add(MODE_ARG, 32'h0000_0000);
        add(MODE_ARG, 32'hFFFF_FFFF);
        add(MODE_STR, 32'h41);
        add(MODE_ARG, 32'h1234_ABCD);
        add(MODE_END, 0);
        add_text("%099u");
        add(MODE_ARG, 5);
        add_text("%7q%s");
        add(MODE_STR, 32'hFF);
        add(MODE_ARG, 1);
        add(MODE_STR, 0);
        add_text("%s");
        add(MODE_NULL, 0);
        add_text("%sZ%0");
        add(MODE_FMT, 0);
        add(3'd7, 32'hFFFF_FFFF);
        add(MODE_STR, 1);
        add(MODE_END, 0);
        drain();

        // small and extreme buffer sizes
        write_size(31'd0);
        add_text("abc%d");
        add(MODE_ARG, 99);
        add(MODE_END, 0);
        drain();
        write_size(31'd1);
        add_text("xy");
        add(MODE_END, 0);
        drain();
        write_size(31'd5);
        add_text("%p");
        add(MODE_ARG, 32'hDEAD_BEEF);
        add(MODE_END, 0);
        drain();

        // random phases with different sizes and idling
        for (int ph_i = 0; ph_i < 3; ph_i++) begin
            case (ph_i)
                0: write_size(31'h7FFF_FFFF);
                1: write_size(31'($urandom_range(2, 20)));
                default: write_size(31'd1024);
            endcase
            send_idle_pct = (ph_i == 0) ? 28 : (ph_i == 1) ? 73 : 0;
            recv_idle_pct = (ph_i == 0) ? 73 : (ph_i == 1) ? 28 : 0;
            while (pending_items.size() < 116) add_random_message();
            drain();
        end
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire
